### rtl/astc_pkg.sv
// ---------------------------------------------------------------------------
// astc_pkg: shared types and constants
// Field widths, register indexes, class codes and the record that travels
// from the classifier front to the accumulator back.
// ---------------------------------------------------------------------------
`default_nettype none

package astc_pkg;

    localparam int ACCEL_W   = 16;
    localparam int LEVEL_W   = 15;
    localparam int SUM_W     = 20;
    localparam int SUM_EXT_W = SUM_W + 1;
    localparam int MAG_W     = ACCEL_W + 1;
    localparam int ROLL_W    = 2;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LEVEL   = 2'd3;

    // Register reset values, Q7.8
    localparam logic [LEVEL_W-1:0] SHAKE_LEVEL_RST  = 15'd3840;
    localparam logic [LEVEL_W-1:0] TILT_LEVEL_RST   = 15'd1024;
    localparam logic [LEVEL_W-1:0] CORNER_LEVEL_RST = 15'd512;
    localparam logic [LEVEL_W-1:0] SIDE_LEVEL_RST   = 15'd1536;

    // Tilt codes
    localparam logic [ROLL_W-1:0] ROLL_UP    = 2'd0;
    localparam logic [ROLL_W-1:0] ROLL_LEVEL = 2'd1;
    localparam logic [ROLL_W-1:0] ROLL_DOWN  = 2'd2;

    // Corner codes, named by the signs of x, y, z (N negative, P positive)
    localparam logic [CODE_W-1:0] CORNER_NNN = 3'd0;
    localparam logic [CODE_W-1:0] CORNER_PNN = 3'd1;
    localparam logic [CODE_W-1:0] CORNER_PPN = 3'd2;
    localparam logic [CODE_W-1:0] CORNER_NPN = 3'd3;
    localparam logic [CODE_W-1:0] CORNER_NNP = 3'd4;
    localparam logic [CODE_W-1:0] CORNER_PNP = 3'd5;
    localparam logic [CODE_W-1:0] CORNER_PPP = 3'd6;
    localparam logic [CODE_W-1:0] CORNER_NPP = 3'd7;

    // Face side codes
    localparam logic [CODE_W-1:0] SIDE_ZNEG = 3'd0;
    localparam logic [CODE_W-1:0] SIDE_YPOS = 3'd1;
    localparam logic [CODE_W-1:0] SIDE_XPOS = 3'd2;
    localparam logic [CODE_W-1:0] SIDE_YNEG = 3'd3;
    localparam logic [CODE_W-1:0] SIDE_XNEG = 3'd4;
    localparam logic [CODE_W-1:0] SIDE_ZPOS = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] shake;
        logic [LEVEL_W-1:0] tilt;
        logic [LEVEL_W-1:0] corner;
        logic [LEVEL_W-1:0] side;
    } levels_t;

    typedef struct packed {
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic [MAG_W-1:0]  mag_z;
        logic              shake_due;
        logic [ROLL_W-1:0] roll_x;
        logic [ROLL_W-1:0] roll_y;
        logic [ROLL_W-1:0] roll_z;
        logic              corner_hit;
        logic [CODE_W-1:0] corner;
        logic              side_hit;
        logic [CODE_W-1:0] face_side;
    } class_t;

endpackage

`default_nettype wire

### rtl/astc_ifs.sv
// ---------------------------------------------------------------------------
// astc channel interfaces
// Sample, result and register write channels, valid/ready with payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface astc_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [astc_pkg::ACCEL_W-1:0] accel_x;
    logic signed [astc_pkg::ACCEL_W-1:0] accel_y;
    logic signed [astc_pkg::ACCEL_W-1:0] accel_z;
    logic                                shake_due;

    modport source (output valid, accel_x, accel_y, accel_z, shake_due, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, shake_due, output ready);
endinterface

interface astc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         shake_detected;
    logic [astc_pkg::ROLL_W-1:0]  roll_x;
    logic [astc_pkg::ROLL_W-1:0]  roll_y;
    logic [astc_pkg::ROLL_W-1:0]  roll_z;
    logic [astc_pkg::CODE_W-1:0]  corner;
    logic [astc_pkg::CODE_W-1:0]  face_side;

    modport source (output valid, shake_detected, roll_x, roll_y, roll_z, corner,
                    face_side, input ready);
    modport sink   (input valid, shake_detected, roll_x, roll_y, roll_z, corner,
                    face_side, output ready);
endinterface

interface astc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [astc_pkg::CFG_IDX_W-1:0] index;
    logic [astc_pkg::LEVEL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/accel_shake_tilt_classifier_unit.sv
// ---------------------------------------------------------------------------
// accel_shake_tilt_classifier_unit: shake and tilt classifier, top level
// Classify accelerometer samples into tilt, corner and face side, and flag
// shake from per-axis window sums of absolute acceleration.
// ---------------------------------------------------------------------------
//
//   channel   dir   payload                                        role
//   -------   ---   --------------------------------------------   -------------
//   sample    in    accel_x, accel_y, accel_z, shake_due           one sample
//   result    out   shake_detected, roll_x/y/z, corner, face_side  one result
//   cfg       in    index, data                                    level writes
//
// One sample a cycle sustained while the result side takes results; a result
// leaves after its sample transfer (classify into the queue, then accumulate
// into the result register). The back's window update sets the rate.
// Reset clears window sums, sample count, held corner/side and the queue, and
// loads the default levels. A stalled result holds in its register while the
// two-entry queue keeps taking samples until it fills.
// ---------------------------------------------------------------------------
`default_nettype none

module accel_shake_tilt_classifier_unit #(
    parameter int WINDOW = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    astc_sample_if.sink    sample,
    astc_result_if.source  result,
    astc_cfg_if.sink       cfg
);
    import astc_pkg::*;

    // Level registers: the user must write them only while the block is idle; the block does not enforce it
    logic [LEVEL_W-1:0] shake_level_reg;
    logic [LEVEL_W-1:0] tilt_level_reg;
    logic [LEVEL_W-1:0] corner_level_reg;
    logic [LEVEL_W-1:0] side_level_reg;
    levels_t            levels;

    logic   push_valid;
    logic   push_ready;
    class_t push_data;
    logic   q_valid;
    logic   q_ready;
    class_t q_data;

    // Always take register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shake_level_reg  <= SHAKE_LEVEL_RST;
            tilt_level_reg   <= TILT_LEVEL_RST;
            corner_level_reg <= CORNER_LEVEL_RST;
            side_level_reg   <= SIDE_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SHAKE_LEVEL:  shake_level_reg  <= cfg.data;
                CFG_TILT_LEVEL:   tilt_level_reg   <= cfg.data;
                CFG_CORNER_LEVEL: corner_level_reg <= cfg.data;
                CFG_SIDE_LEVEL:   side_level_reg   <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign levels.shake  = shake_level_reg;
    assign levels.tilt   = tilt_level_reg;
    assign levels.corner = corner_level_reg;
    assign levels.side   = side_level_reg;

    // Front: classify each sample against the levels
    astc_front u_front (
        .sample     (sample),
        .levels     (levels),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue: absorb a stall at the result side
    astc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // Back: advance the window, hold corner/side, register the result
    astc_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .shake_level (levels.shake),
        .pop_valid   (q_valid),
        .pop_ready   (q_ready),
        .pop_data    (q_data),
        .result      (result)
    );

    // A queued item moved to the back must show up as a result next cycle
    a_pop_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> result.valid
    ) else $error("queued item did not reach the result register");

    // The front stalls only when the queue has something to drain
    a_stall_means_queued: assert property (
        @(posedge clk) disable iff (!rst_n)
        !sample.ready |-> q_valid
    ) else $error("sample stalled with an empty queue");

    // The back takes a queued item whenever the result register is free
    a_free_means_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        !result.valid |-> q_ready
    ) else $error("back not ready with an empty result register");

endmodule

`default_nettype wire

### rtl/astc_front.sv
// ---------------------------------------------------------------------------
// astc_front: sample classifier
// Turn one sample into magnitudes, tilt codes and corner/side matches.
// ---------------------------------------------------------------------------
`default_nettype none

module astc_front (
    astc_sample_if.sink        sample,
    input  astc_pkg::levels_t  levels,
    output logic               push_valid,
    input  logic               push_ready,
    output astc_pkg::class_t   push_data
);
    import astc_pkg::*;

    function automatic logic at_or_above(input logic [ACCEL_W-1:0] a,
                                         input logic [LEVEL_W-1:0] lvl);
        logic signed [MAG_W-1:0] a_ext;
        logic signed [MAG_W-1:0] l_ext;
        a_ext = $signed({a[ACCEL_W-1], a});
        l_ext = $signed({2'b00, lvl});
        return a_ext >= l_ext;
    endfunction

    function automatic logic at_or_below_neg(input logic [ACCEL_W-1:0] a,
                                             input logic [LEVEL_W-1:0] lvl);
        logic signed [MAG_W-1:0] a_ext;
        logic signed [MAG_W-1:0] l_ext;
        a_ext = $signed({a[ACCEL_W-1], a});
        l_ext = $signed({2'b00, lvl});
        return a_ext <= -l_ext;
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(input logic [ACCEL_W-1:0] a);
        logic [MAG_W-1:0] ext;
        ext = {a[ACCEL_W-1], a};
        return a[ACCEL_W-1] ? (~ext + MAG_W'(1)) : ext;
    endfunction

    function automatic logic [ROLL_W-1:0] roll_of(input logic [ACCEL_W-1:0] a,
                                                  input logic [LEVEL_W-1:0] lvl);
        logic [ROLL_W-1:0] r;
        if (at_or_above(a, lvl))
            r = ROLL_UP;
        else if (at_or_below_neg(a, lvl))
            r = ROLL_DOWN;
        else
            r = ROLL_LEVEL;
        return r;
    endfunction

    logic xn, xp, yn, yp, zn, zp;
    logic sxn, sxp, syn, syp, szn, szp;

    assign xn = at_or_below_neg(sample.accel_x, levels.corner);
    assign xp = at_or_above(sample.accel_x, levels.corner);
    assign yn = at_or_below_neg(sample.accel_y, levels.corner);
    assign yp = at_or_above(sample.accel_y, levels.corner);
    assign zn = at_or_below_neg(sample.accel_z, levels.corner);
    assign zp = at_or_above(sample.accel_z, levels.corner);

    assign sxn = at_or_below_neg(sample.accel_x, levels.side);
    assign sxp = at_or_above(sample.accel_x, levels.side);
    assign syn = at_or_below_neg(sample.accel_y, levels.side);
    assign syp = at_or_above(sample.accel_y, levels.side);
    assign szn = at_or_below_neg(sample.accel_z, levels.side);
    assign szp = at_or_above(sample.accel_z, levels.side);

    always_comb
    begin
        push_data.mag_x     = magnitude(sample.accel_x);
        push_data.mag_y     = magnitude(sample.accel_y);
        push_data.mag_z     = magnitude(sample.accel_z);
        push_data.shake_due = sample.shake_due;
        push_data.roll_x    = roll_of(sample.accel_x, levels.tilt);
        push_data.roll_y    = roll_of(sample.accel_y, levels.tilt);
        push_data.roll_z    = roll_of(sample.accel_z, levels.tilt);

        // Corners in priority order; no match keeps the held corner
        push_data.corner_hit = 1'b1;
        if (xn && yn && zn)
            push_data.corner = CORNER_NNN;
        else if (xp && yn && zn)
            push_data.corner = CORNER_PNN;
        else if (xp && yp && zn)
            push_data.corner = CORNER_PPN;
        else if (xn && yp && zn)
            push_data.corner = CORNER_NPN;
        else if (xn && yn && zp)
            push_data.corner = CORNER_NNP;
        else if (xp && yn && zp)
            push_data.corner = CORNER_PNP;
        else if (xp && yp && zp)
            push_data.corner = CORNER_PPP;
        else if (xn && yp && zp)
            push_data.corner = CORNER_NPP;
        else
        begin
            push_data.corner_hit = 1'b0;
            push_data.corner     = CORNER_NNN;
        end

        push_data.side_hit = 1'b1;
        if (szn)
            push_data.face_side = SIDE_ZNEG;
        else if (szp)
            push_data.face_side = SIDE_ZPOS;
        else if (sxn)
            push_data.face_side = SIDE_XNEG;
        else if (sxp)
            push_data.face_side = SIDE_XPOS;
        else if (syn)
            push_data.face_side = SIDE_YNEG;
        else if (syp)
            push_data.face_side = SIDE_YPOS;
        else
        begin
            push_data.side_hit  = 1'b0;
            push_data.face_side = SIDE_ZNEG;
        end
    end

    assign push_valid   = sample.valid;
    assign sample.ready = push_ready;

endmodule

`default_nettype wire

### rtl/astc_queue.sv
// ---------------------------------------------------------------------------
// astc_queue: two-entry queue
// Decouple the classifier front from the accumulator back.
// ---------------------------------------------------------------------------
`default_nettype none

module astc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  astc_pkg::class_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output astc_pkg::class_t  pop_data
);
    import astc_pkg::*;

    class_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

### rtl/astc_back.sv
// ---------------------------------------------------------------------------
// astc_back: window accumulator and result register
// Keep the per-axis window sums, judge shake, hold corner/side, drive results.
// ---------------------------------------------------------------------------
`default_nettype none

module astc_back #(
    parameter int WINDOW = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [astc_pkg::LEVEL_W-1:0]    shake_level,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  astc_pkg::class_t                pop_data,
    astc_result_if.source                   result
);
    import astc_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int LIM_W = LEVEL_W + CNT_W;
    localparam int CMP_W = (LIM_W > SUM_W) ? LIM_W : SUM_W;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [MAG_W-1:0] m);
        logic [SUM_EXT_W-1:0] r;
        r = {1'b0, s} + SUM_EXT_W'(m);
        return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
    endfunction

    logic [SUM_W-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic [SUM_W-1:0]  sum_x_next, sum_y_next, sum_z_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CODE_W-1:0] held_corner_reg, held_corner_next;
    logic [CODE_W-1:0] held_side_reg, held_side_next;
    logic              out_valid_reg;
    logic              shake_reg, shake_next;
    logic [ROLL_W-1:0] roll_x_reg, roll_y_reg, roll_z_reg;
    logic              take;
    logic              window_full;
    logic [CMP_W-1:0]  limit;
    logic              over;

    assign pop_ready   = !out_valid_reg || result.ready;
    assign take        = pop_valid && pop_ready;
    assign window_full = (count_reg >= CNT_W'(WINDOW));
    assign limit       = CMP_W'(LIM_W'(shake_level) * LIM_W'(WINDOW));
    assign over        = (CMP_W'(sum_x_reg) > limit) || (CMP_W'(sum_y_reg) > limit)
                         || (CMP_W'(sum_z_reg) > limit);

    always_comb
    begin
        // Judge the finished window, then restart it with this sample
        shake_next = window_full && pop_data.shake_due && over;
        sum_x_next = sat_add(window_full ? '0 : sum_x_reg, pop_data.mag_x);
        sum_y_next = sat_add(window_full ? '0 : sum_y_reg, pop_data.mag_y);
        sum_z_next = sat_add(window_full ? '0 : sum_z_reg, pop_data.mag_z);
        count_next = window_full ? CNT_W'(1) : count_reg + CNT_W'(1);
        held_corner_next = pop_data.corner_hit ? pop_data.corner : held_corner_reg;
        held_side_next   = pop_data.side_hit ? pop_data.face_side : held_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_z_reg       <= '0;
            count_reg       <= '0;
            held_corner_reg <= '0;
            held_side_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                sum_x_reg       <= sum_x_next;
                sum_y_reg       <= sum_y_next;
                sum_z_reg       <= sum_z_next;
                count_reg       <= count_next;
                held_corner_reg <= held_corner_next;
                held_side_reg   <= held_side_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            shake_reg  <= shake_next;
            roll_x_reg <= pop_data.roll_x;
            roll_y_reg <= pop_data.roll_y;
            roll_z_reg <= pop_data.roll_z;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.shake_detected = shake_reg;
    assign result.roll_x         = roll_x_reg;
    assign result.roll_y         = roll_y_reg;
    assign result.roll_z         = roll_z_reg;
    assign result.corner         = held_corner_reg;
    assign result.face_side      = held_side_reg;

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: shake and tilt classifier check
// Drive accelerometer samples through the valid/ready channels, predict each
// result from a private model of window sums, tilt, corner and face side, and
// compare every result transfer in order. Level registers are reprogrammed
// between phases while the block is idle, extremes included.
// ---------------------------------------------------------------------------

module testbench;

    import astc_pkg::*;

    localparam int WINDOW = 10;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam int PHASE_ITEMS = 120;
    localparam int SETTLE_CYCLES = 4;

    // Stimulus shapes chosen per window of samples
    typedef enum int {
        WIN_RANDOM,
        WIN_SHAKE_EDGE,
        WIN_THRESHOLD,
        WIN_QUIET
    } window_mode_t;

    // One expected result transfer
    typedef struct packed {
        logic              shake;
        logic [ROLL_W-1:0] roll_x;
        logic [ROLL_W-1:0] roll_y;
        logic [ROLL_W-1:0] roll_z;
        logic [CODE_W-1:0] corner;
        logic [CODE_W-1:0] face_side;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    astc_sample_if smp_ch ();
    astc_result_if res_ch ();
    astc_cfg_if    cfg_ch ();

    accel_shake_tilt_classifier_unit #(
        .WINDOW (WINDOW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #2 clk = ~clk;

    // Predictor copy of the levels and the window state
    logic [LEVEL_W-1:0] lvl_shake  = SHAKE_LEVEL_RST;
    logic [LEVEL_W-1:0] lvl_tilt   = TILT_LEVEL_RST;
    logic [LEVEL_W-1:0] lvl_corner = CORNER_LEVEL_RST;
    logic [LEVEL_W-1:0] lvl_side   = SIDE_LEVEL_RST;
    logic [SUM_W-1:0]   win_sum_x  = '0;
    logic [SUM_W-1:0]   win_sum_y  = '0;
    logic [SUM_W-1:0]   win_sum_z  = '0;
    int                 win_count  = 0;
    logic [CODE_W-1:0]  last_corner = CORNER_NNN;
    logic [CODE_W-1:0]  last_side   = SIDE_ZNEG;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    bit       burst_mode = 1'b0;

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Add |a| to a window sum, saturating at the top of the sum width
    function automatic logic [SUM_W-1:0] sat_accumulate(input logic [SUM_W-1:0] acc,
                                                        input int a);
        logic [SUM_W:0] wide;
        int m;
        m = (a < 0) ? -a : a;
        wide = {1'b0, acc} + (SUM_W+1)'(m[MAG_W-1:0]);
        return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
    endfunction

    // Up wins over down when the level is zero
    function automatic logic [ROLL_W-1:0] tilt_code(input int a, input int lvl);
        if (a >= lvl)
            return ROLL_UP;
        if (a <= -lvl)
            return ROLL_DOWN;
        return ROLL_LEVEL;
    endfunction

    // Advance the window and the held codes by one accepted sample
    function automatic verdict_t classify_sample(input logic signed [ACCEL_W-1:0] ax, ay, az,
                                                 input logic due);
        verdict_t v;
        int x, y, z, c, s, t;
        longint lim;
        logic xn, xp, yn, yp, zn, zp;
        x = int'(ax);
        y = int'(ay);
        z = int'(az);
        c = int'(lvl_corner);
        s = int'(lvl_side);
        t = int'(lvl_tilt);
        v.shake = 1'b0;

        // A full window is judged by the sample that follows it, which then
        // opens the next window
        if (win_count >= WINDOW) begin
            lim = longint'(lvl_shake);
            lim = lim * WINDOW;
            if (due && (win_sum_x > lim || win_sum_y > lim || win_sum_z > lim))
                v.shake = 1'b1;
            win_sum_x = '0;
            win_sum_y = '0;
            win_sum_z = '0;
            win_count = 0;
        end
        win_sum_x = sat_accumulate(win_sum_x, x);
        win_sum_y = sat_accumulate(win_sum_y, y);
        win_sum_z = sat_accumulate(win_sum_z, z);
        win_count = win_count + 1;

        xn = x <= -c;
        xp = x >= c;
        yn = y <= -c;
        yp = y >= c;
        zn = z <= -c;
        zp = z >= c;
        if (xn && yn && zn)      last_corner = CORNER_NNN;
        else if (xp && yn && zn) last_corner = CORNER_PNN;
        else if (xp && yp && zn) last_corner = CORNER_PPN;
        else if (xn && yp && zn) last_corner = CORNER_NPN;
        else if (xn && yn && zp) last_corner = CORNER_NNP;
        else if (xp && yn && zp) last_corner = CORNER_PNP;
        else if (xp && yp && zp) last_corner = CORNER_PPP;
        else if (xn && yp && zp) last_corner = CORNER_NPP;

        if (z <= -s)      last_side = SIDE_ZNEG;
        else if (z >= s)  last_side = SIDE_ZPOS;
        else if (x <= -s) last_side = SIDE_XNEG;
        else if (x >= s)  last_side = SIDE_XPOS;
        else if (y <= -s) last_side = SIDE_YNEG;
        else if (y >= s)  last_side = SIDE_YPOS;

        v.roll_x    = tilt_code(x, t);
        v.roll_y    = tilt_code(y, t);
        v.roll_z    = tilt_code(z, t);
        v.corner    = last_corner;
        v.face_side = last_side;
        return v;
    endfunction

    // -----------------------------------------------------------------------
    // Value helpers
    // -----------------------------------------------------------------------

    // Mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic signed [ACCEL_W-1:0] to_accel(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[ACCEL_W-1:0];
    endfunction

    function automatic logic signed [ACCEL_W-1:0] rand_sign(input int m);
        return to_accel($urandom_range(1) ? -m : m);
    endfunction

    // Land on a level, one below it or one above it, either sign
    function automatic logic signed [ACCEL_W-1:0] near_level(input logic [LEVEL_W-1:0] lvl);
        int v, off;
        off = $urandom_range(2);
        v = int'(lvl);
        v = v + off - 1;
        return rand_sign(v);
    endfunction

    // -----------------------------------------------------------------------
    // Channel tasks
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one sample and record its prediction at the transfer
    task automatic send_sample(input logic signed [ACCEL_W-1:0] ax, ay, az,
                               input logic due);
        int gap;
        gap = burst_mode ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk);
            smp_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        smp_ch.valid     <= 1'b1;
        smp_ch.accel_x   <= ax;
        smp_ch.accel_y   <= ay;
        smp_ch.accel_z   <= az;
        smp_ch.shake_due <= due;
        do
            @(posedge clk);
        while (smp_ch.ready !== 1'b1);
        pending_verdicts.push_back(classify_sample(ax, ay, az, due));
    endtask

    // Drop valid, let every result drain, then give the pipe a few cycles
    task automatic settle_idle();
        @(negedge clk);
        smp_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_level(input logic [CFG_IDX_W-1:0] idx,
                               input logic [LEVEL_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_SHAKE_LEVEL:  lvl_shake  = val;
            CFG_TILT_LEVEL:   lvl_tilt   = val;
            CFG_CORNER_LEVEL: lvl_corner = val;
            CFG_SIDE_LEVEL:   lvl_side   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_levels(input logic [LEVEL_W-1:0] sh, ti, co, si);
        settle_idle();
        write_level(CFG_SHAKE_LEVEL, sh);
        write_level(CFG_TILT_LEVEL, ti);
        write_level(CFG_CORNER_LEVEL, co);
        write_level(CFG_SIDE_LEVEL, si);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset levels: extremes, every corner and side at its exact boundary,
    // near misses that hold the previous code, tilt boundaries
    task automatic test_classification();
        int k, m;
        m = int'(CORNER_LEVEL_RST);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
        // walk the corners in priority order: x+ on 1,2,5,6; y+ on 2,3,6,7; z+ on 4..7
        for (k = 0; k < 8; k++)
            send_sample(to_accel((k % 4 == 1 || k % 4 == 2) ? m : -m),
                        to_accel((k % 4 >= 2) ? m : -m),
                        to_accel((k >= 4) ? m : -m), 1'b1);
        send_sample(to_accel(m - 1), -16'sd600, 16'sd600, 1'b1);
        m = int'(SIDE_LEVEL_RST);
        send_sample(16'sd0, 16'sd0, to_accel(-m), 1'b1);
        send_sample(16'sd0, 16'sd0, to_accel(m), 1'b1);
        send_sample(to_accel(-m), 16'sd0, 16'sd0, 1'b1);
        send_sample(to_accel(m), 16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd0, to_accel(-m), 16'sd0, 1'b1);
        send_sample(16'sd0, to_accel(m), 16'sd0, 1'b1);
        send_sample(to_accel(m - 1), to_accel(1 - m), to_accel(m - 1), 1'b1);
        m = int'(TILT_LEVEL_RST);
        send_sample(to_accel(m), to_accel(-m), to_accel(m - 1), 1'b1);
    endtask

    // Zero levels: at and below minus both hold at zero, priority decides
    task automatic test_zero_levels();
        program_levels('0, '0, '0, '0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd1, -16'sd1, 16'sd0, 1'b0);
        send_sample(-16'sd1, 16'sd1, 16'sd1, 1'b1);
    endtask

    // Top levels: only the very ends of the input range reach them
    task automatic test_max_levels();
        program_levels(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        send_sample(16'sd32767, -16'sd32767, -16'sd32768, 1'b1);
        send_sample(16'sd32766, -16'sd32766, 16'sd32766, 1'b1);
    endtask

    // Random samples shaped window by window; each window picks a mode that
    // stresses shake sums, threshold edges or plain random data
    task automatic run_window_phase(input int count);
        int i, k, pos, hot, bump_pos, r, m;
        bit bump;
        window_mode_t mode;
        logic signed [ACCEL_W-1:0] a [3];
        mode = WIN_RANDOM;
        hot = 0;
        bump = 1'b0;
        bump_pos = 0;
        for (i = 0; i < count; i++) begin
            pos = (win_count >= WINDOW) ? 0 : win_count;
            if (pos == 0) begin
                r = $urandom_range(9);
                mode = (r < 3) ? WIN_RANDOM : (r < 6) ? WIN_SHAKE_EDGE :
                       (r < 8) ? WIN_THRESHOLD : WIN_QUIET;
                hot = $urandom_range(2);
                bump = 1'($urandom_range(1));
                bump_pos = $urandom_range(WINDOW - 1);
                burst_mode = ($urandom_range(3) == 0);
            end
            for (k = 0; k < 3; k++) begin
                case (mode)
                    WIN_RANDOM:
                        a[k] = ACCEL_W'($urandom_range(16'hFFFF));
                    WIN_SHAKE_EDGE: begin
                        // hot axis sums to the limit exactly, or one past it
                        m = int'(lvl_shake);
                        if (k != hot)
                            a[k] = rand_sign($urandom_range(m));
                        else if (bump && pos == bump_pos)
                            a[k] = to_accel(-(m + 1));
                        else
                            a[k] = rand_sign(m);
                    end
                    WIN_THRESHOLD: begin
                        r = $urandom_range(4);
                        a[k] = (r == 0) ? near_level(lvl_tilt) :
                               (r == 1) ? near_level(lvl_corner) :
                               (r == 2) ? near_level(lvl_side) :
                               (r == 3) ? near_level(lvl_shake) : 16'sd0;
                    end
                    default:
                        a[k] = to_accel(int'($urandom_range(4096)) - 2048);
                endcase
            end
            // hold off now and then until the block has emptied
            if (i == count / 2 || $urandom_range(149) == 0)
                settle_idle();
            send_sample(a[0], a[1], a[2], $urandom_range(3) != 0);
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_random_windows();
        program_levels(SHAKE_LEVEL_RST, TILT_LEVEL_RST, CORNER_LEVEL_RST, SIDE_LEVEL_RST);
        run_window_phase(PHASE_ITEMS);
        program_levels('0, '0, '0, '0);
        run_window_phase(PHASE_ITEMS);
        program_levels(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        run_window_phase(PHASE_ITEMS);
        program_levels(LEVEL_W'($urandom_range(LEVEL_MAX)), LEVEL_W'($urandom_range(LEVEL_MAX)),
                       LEVEL_W'($urandom_range(LEVEL_MAX)), LEVEL_W'($urandom_range(LEVEL_MAX)));
        run_window_phase(PHASE_ITEMS);
        program_levels(LEVEL_W'($urandom_range(8192)), LEVEL_W'($urandom_range(4096)),
                       LEVEL_W'($urandom_range(4096)), LEVEL_W'($urandom_range(4096)));
        run_window_phase(PHASE_ITEMS);
        program_levels('0, LEVEL_MAX, '0, LEVEL_MAX);
        run_window_phase(PHASE_ITEMS);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random back-pressure and in-order comparison
    // -----------------------------------------------------------------------

    initial begin
        int run;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            // accept for a stretch, then stall for a random while
            run = ($urandom_range(7) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
            @(negedge clk);
            res_ch.ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            run = idle_len();
            if (run > 0) begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        verdict_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end
            else begin
                want = pending_verdicts.pop_front();
                if (res_ch.shake_detected !== want.shake)
                    report_mismatch("shake_detected", res_ch.shake_detected, want.shake);
                if (res_ch.roll_x !== want.roll_x)
                    report_mismatch("roll_x", res_ch.roll_x, want.roll_x);
                if (res_ch.roll_y !== want.roll_y)
                    report_mismatch("roll_y", res_ch.roll_y, want.roll_y);
                if (res_ch.roll_z !== want.roll_z)
                    report_mismatch("roll_z", res_ch.roll_z, want.roll_z);
                if (res_ch.corner !== want.corner)
                    report_mismatch("corner", res_ch.corner, want.corner);
                if (res_ch.face_side !== want.face_side)
                    report_mismatch("face_side", res_ch.face_side, want.face_side);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial begin
        rst_n            <= 1'b0;
        smp_ch.valid     <= 1'b0;
        smp_ch.accel_x   <= '0;
        smp_ch.accel_y   <= '0;
        smp_ch.accel_z   <= '0;
        smp_ch.shake_due <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_SHAKE_LEVEL;
        cfg_ch.data      <= '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_classification();
        test_zero_levels();
        test_max_levels();
        test_random_windows();

        // drain, then watch a few more cycles for stray transfers
        settle_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
